/* rtl/sts_pkg.sv */
// Shared constants and types for the sorted table predecessor search block.
package sts_pkg;

   localparam int VALUE_W             = 64;
   localparam int POS_W               = 10;
   localparam int DEFAULT_TABLE_DEPTH = 1024;

   localparam logic CMD_LOAD  = 1'b0;
   localparam logic CMD_QUERY = 1'b1;

   typedef logic signed [VALUE_W-1:0] value_type;
   typedef logic [POS_W-1:0]          position_type;

endpackage

/* rtl/sorted_table_predecessor_search_top.sv */
// Sorted version table with append loads and floor (predecessor) binary search queries.
// A load's result strobes the cycle after start, and the next item may follow.
// A query with an empty table answers the cycle after start; otherwise it reads entry 0,
// then the last entry unless entry 0 is above the key, then runs binary search probes,
// each a read state and a compare state, through the single RAM read port.
// Synchronous reset empties the table (count to zero); results cannot be stalled.
module sorted_table_predecessor_search_top #(
   parameter int TABLE_DEPTH = sts_pkg::DEFAULT_TABLE_DEPTH
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  logic                  req_cmd,
   input  logic                  req_first,
   input  sts_pkg::value_type    req_value,
   output logic                  rsp_valid,
   output logic                  rsp_found,
   output sts_pkg::position_type rsp_position,
   output logic                  rsp_overflow
);

   import sts_pkg::*;

   localparam int IDX_W = $clog2(TABLE_DEPTH);
   localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
   localparam int HW    = CNT_W + 1;

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_FIRST = 3'd1;
   localparam logic [2:0] ST_LAST  = 3'd2;
   localparam logic [2:0] ST_PROBE = 3'd3;
   localparam logic [2:0] ST_CMP   = 3'd4;

   logic [2:0]             state_ff, state_in;
   logic [CNT_W-1:0]       count_ff, count_in;
   value_type              key_ff, key_in;
   logic signed [HW-1:0]   lo_ff, lo_in;
   logic signed [HW-1:0]   hi_ff, hi_in;
   logic [CNT_W-1:0]       mid_ff, mid_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   rsp_found_ff, rsp_found_in;
   position_type           rsp_position_ff, rsp_position_in;
   logic                   rsp_overflow_ff, rsp_overflow_in;

   logic                   accept;
   logic [CNT_W-1:0]       count_eff;
   logic [CNT_W-1:0]       last_idx;
   logic [CNT_W:0]         mid_sum;
   logic [CNT_W-1:0]       mid_next;
   logic signed [HW-1:0]   mid_s;
   logic [CNT_W-1:0]       pos_src;
   logic [CNT_W+POS_W-1:0] pos_wide;
   logic                   wr_en;
   logic [IDX_W-1:0]       wr_addr;
   logic                   rd_en;
   logic [IDX_W-1:0]       rd_addr;
   logic [VALUE_W-1:0]     rd_data;
   value_type              rd_value;

   sts_ram #(
      .WIDTH (VALUE_W),
      .DEPTH (TABLE_DEPTH)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (req_value),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign rd_value  = $signed(rd_data);
   assign accept    = start && !busy;
   assign count_eff = req_first ? '0 : count_ff;
   assign last_idx  = count_ff - CNT_W'(1);
   assign mid_sum   = {1'b0, lo_ff[CNT_W-1:0]} + {1'b0, hi_ff[CNT_W-1:0]};
   assign mid_next  = mid_sum[CNT_W:1];
   assign mid_s     = $signed({1'b0, mid_ff});
   assign pos_wide  = {{POS_W{1'b0}}, pos_src};

   always_comb begin
      state_in        = state_ff;
      count_in        = count_ff;
      key_in          = key_ff;
      lo_in           = lo_ff;
      hi_in           = hi_ff;
      mid_in          = mid_ff;
      rsp_valid_in    = 1'b0;
      rsp_found_in    = rsp_found_ff;
      rsp_overflow_in = rsp_overflow_ff;
      pos_src         = '0;
      wr_en           = 1'b0;
      wr_addr         = '0;
      rd_en           = 1'b0;
      rd_addr         = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               key_in = req_value;
               if (req_cmd == CMD_LOAD) begin
                  rsp_valid_in = 1'b1;
                  rsp_found_in = 1'b0;
                  if (count_eff >= CNT_W'(TABLE_DEPTH)) begin
                     rsp_overflow_in = 1'b1;
                     count_in        = count_eff;
                  end else begin
                     rsp_overflow_in = 1'b0;
                     pos_src         = count_eff;
                     wr_en           = 1'b1;
                     wr_addr         = count_eff[IDX_W-1:0];
                     count_in        = count_eff + CNT_W'(1);
                  end
               end else if (count_ff == '0) begin
                  rsp_valid_in    = 1'b1;
                  rsp_found_in    = 1'b0;
                  rsp_overflow_in = 1'b0;
               end else begin
                  rd_en    = 1'b1;
                  rd_addr  = '0;
                  state_in = ST_FIRST;
               end
            end
         end
         ST_FIRST: begin
            if (rd_value > key_ff) begin
               rsp_valid_in    = 1'b1;
               rsp_found_in    = 1'b0;
               rsp_overflow_in = 1'b0;
               state_in        = ST_IDLE;
            end else begin
               rd_en    = 1'b1;
               rd_addr  = last_idx[IDX_W-1:0];
               state_in = ST_LAST;
            end
         end
         ST_LAST: begin
            if (rd_value == key_ff) begin
               rsp_valid_in    = 1'b1;
               rsp_found_in    = 1'b1;
               rsp_overflow_in = 1'b0;
               pos_src         = last_idx;
               state_in        = ST_IDLE;
            end else begin
               lo_in    = '0;
               hi_in    = $signed({1'b0, last_idx});
               state_in = ST_PROBE;
            end
         end
         ST_PROBE: begin
            if (lo_ff <= hi_ff) begin
               rd_en    = 1'b1;
               rd_addr  = mid_next[IDX_W-1:0];
               mid_in   = mid_next;
               state_in = ST_CMP;
            end else begin
               rsp_valid_in    = 1'b1;
               rsp_overflow_in = 1'b0;
               rsp_found_in    = !hi_ff[HW-1];
               pos_src         = hi_ff[HW-1] ? '0 : hi_ff[CNT_W-1:0];
               state_in        = ST_IDLE;
            end
         end
         ST_CMP: begin
            if (rd_value > key_ff) begin
               hi_in    = mid_s - HW'(1);
               state_in = ST_PROBE;
            end else if (rd_value < key_ff) begin
               lo_in    = mid_s + HW'(1);
               state_in = ST_PROBE;
            end else begin
               rsp_valid_in    = 1'b1;
               rsp_found_in    = 1'b1;
               rsp_overflow_in = 1'b0;
               pos_src         = mid_ff;
               state_in        = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      rsp_position_in = pos_wide[POS_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff          <= key_in;
      lo_ff           <= lo_in;
      hi_ff           <= hi_in;
      mid_ff          <= mid_in;
      rsp_found_ff    <= rsp_found_in;
      rsp_position_ff <= rsp_position_in;
      rsp_overflow_ff <= rsp_overflow_in;
   end

   assign busy         = (state_ff != ST_IDLE);
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_found    = rsp_found_ff;
   assign rsp_position = rsp_position_ff;
   assign rsp_overflow = rsp_overflow_ff;

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(TABLE_DEPTH))
      else $error("entry count above table depth");

   a_load_one_cycle: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_cmd == CMD_LOAD) |=> rsp_valid)
      else $error("load result missing");

   a_result_when_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result strobed while search still running");

   a_found_excl_overflow: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_found && rsp_overflow))
      else $error("found and overflow both set");

   a_overflow_full: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_overflow) |-> (count_ff == CNT_W'(TABLE_DEPTH)))
      else $error("overflow reported with room in table");
`endif

endmodule

/* rtl/sts_ram.sv */
// Generic single-write, single-read synchronous RAM with registered read data.
module sts_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* dv/sorted_table_predecessor_search_top_tb.sv */
// Self-checking testbench: directed table, then random load and query traffic.
module sorted_table_predecessor_search_top_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import sts_pkg::*;

   localparam int DEPTH = DEFAULT_TABLE_DEPTH;
   localparam int DRAIN_CYCLES = 32;
   localparam int PHASE_ITEMS = 35;
   localparam value_type VMIN = {1'b1, {(VALUE_W-1){1'b0}}};
   localparam value_type VMAX = {1'b0, {(VALUE_W-1){1'b1}}};

   typedef struct packed {
      logic         found;
      position_type position;
      logic         overflow;
   } answer_type;

   typedef struct packed {
      logic       cmd;
      logic       first;
      value_type  value;
      logic       fixed;
      answer_type answer;
   } directed_row_type;

   localparam answer_type MISS = '{1'b0, 10'd0, 1'b0};
   localparam int NUM_ROWS = 25;
   localparam directed_row_type DIRECTED_ROWS [NUM_ROWS] = '{
      '{CMD_QUERY, 1'b0, VMIN,          1'b1, MISS},
      '{CMD_QUERY, 1'b0, VMAX,          1'b1, MISS},
      '{CMD_LOAD,  1'b0, VMIN,          1'b1, '{1'b0, 10'd0, 1'b0}},
      '{CMD_QUERY, 1'b0, VMIN,          1'b1, '{1'b1, 10'd0, 1'b0}},
      '{CMD_LOAD,  1'b0, -64'sd5,       1'b1, '{1'b0, 10'd1, 1'b0}},
      '{CMD_LOAD,  1'b0, -64'sd5,       1'b1, '{1'b0, 10'd2, 1'b0}},
      '{CMD_LOAD,  1'b0, 64'sd0,        1'b1, '{1'b0, 10'd3, 1'b0}},
      '{CMD_LOAD,  1'b0, 64'sd7,        1'b1, '{1'b0, 10'd4, 1'b0}},
      '{CMD_LOAD,  1'b0, VMAX,          1'b1, '{1'b0, 10'd5, 1'b0}},
      '{CMD_QUERY, 1'b0, VMAX,          1'b1, '{1'b1, 10'd5, 1'b0}},
      '{CMD_QUERY, 1'b0, -64'sd5,       1'b0, MISS},
      '{CMD_QUERY, 1'b0, 64'sd3,        1'b0, MISS},
      '{CMD_QUERY, 1'b0, -64'sd6,       1'b0, MISS},
      '{CMD_QUERY, 1'b0, VMAX - 64'sd1, 1'b0, MISS},
      '{CMD_LOAD,  1'b1, 64'sd100,      1'b1, '{1'b0, 10'd0, 1'b0}},
      '{CMD_QUERY, 1'b0, 64'sd99,       1'b1, MISS},
      '{CMD_QUERY, 1'b0, 64'sd100,      1'b1, '{1'b1, 10'd0, 1'b0}},
      '{CMD_QUERY, 1'b1, 64'sd101,      1'b0, MISS},
      '{CMD_LOAD,  1'b0, 64'sd50,       1'b1, '{1'b0, 10'd1, 1'b0}},
      '{CMD_LOAD,  1'b0, 64'sd200,      1'b1, '{1'b0, 10'd2, 1'b0}},
      '{CMD_LOAD,  1'b0, 64'sd10,       1'b1, '{1'b0, 10'd3, 1'b0}},
      '{CMD_QUERY, 1'b0, 64'sd60,       1'b0, MISS},
      '{CMD_QUERY, 1'b0, 64'sd150,      1'b0, MISS},
      '{CMD_QUERY, 1'b0, 64'sd5,        1'b1, MISS},
      '{CMD_QUERY, 1'b1, 64'sd200,      1'b0, MISS}
   };
   localparam int IDLE_PCTS [3] = '{0, 79, 16};

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         start = 1'b0;
   logic         req_cmd = CMD_LOAD;
   logic         req_first = 1'b0;
   value_type    req_value = '0;
   logic         busy;
   logic         rsp_valid;
   logic         rsp_found;
   position_type rsp_position;
   logic         rsp_overflow;

   value_type  version_mirror [DEPTH];
   int         entry_total = 0;
   answer_type pending_answers [$];
   int         issued_total = 0;
   int         error_count = 0;

   sorted_table_predecessor_search_top u_top (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .busy         (busy),
      .req_cmd      (req_cmd),
      .req_first    (req_first),
      .req_value    (req_value),
      .rsp_valid    (rsp_valid),
      .rsp_found    (rsp_found),
      .rsp_position (rsp_position),
      .rsp_overflow (rsp_overflow)
   );

   always #5 clock = ~clock;

   task automatic report_error(input string msg);
      $display("ERROR at %0t ns: %s", $time, msg);
      error_count++;
   endtask

   function automatic answer_type compute_lookup(input logic cmd, input logic first,
                                                 input value_type key);
      answer_type a;
      int         lo;
      int         hi;
      int         mid;
      logic       hit;
      a = '0;
      if (cmd == CMD_LOAD) begin
         if (first)
            entry_total = 0;
         if (entry_total >= DEPTH) begin
            a.overflow = 1'b1;
         end else begin
            version_mirror[entry_total] = key;
            a.position = position_type'(entry_total);
            entry_total++;
         end
      end else if (entry_total != 0 && version_mirror[0] <= key) begin
         if (version_mirror[entry_total-1] == key) begin
            a.found = 1'b1;
            a.position = position_type'(entry_total - 1);
         end else begin
            lo = 0;
            hi = entry_total - 1;
            hit = 1'b0;
            while (!hit && lo <= hi) begin
               mid = (lo + hi) / 2;
               if (version_mirror[mid] > key) begin
                  hi = mid - 1;
               end else if (version_mirror[mid] < key) begin
                  lo = mid + 1;
               end else begin
                  hit = 1'b1;
                  a.found = 1'b1;
                  a.position = position_type'(mid);
               end
            end
            if (!hit && hi >= 0) begin
               a.found = 1'b1;
               a.position = position_type'(hi);
            end
         end
      end
      return a;
   endfunction

   function automatic value_type random_value();
      return value_type'({$urandom, $urandom});
   endfunction

   function automatic value_type sat_add(input value_type a, input value_type step);
      return (a > VMAX - step) ? VMAX : a + step;
   endfunction

   function automatic value_type random_step();
      case ($urandom_range(3))
         0: return '0;
         3: return value_type'({$urandom, $urandom} >> 6);
         default: return value_type'($urandom_range(1, 100));
      endcase
   endfunction

   function automatic value_type pick_target();
      value_type anchor;
      if (entry_total == 0)
         return random_value();
      anchor = version_mirror[$urandom_range(entry_total - 1)];
      case ($urandom_range(7))
         0, 1: return anchor;
         2: return sat_add(anchor, 64'sd1);
         3: return (anchor == VMIN) ? VMIN : anchor - 64'sd1;
         4: return VMIN;
         5: return VMAX;
         6: return sat_add(anchor, random_step());
         default: return random_value();
      endcase
   endfunction

   task automatic issue(input logic cmd, input logic first, input value_type value,
                        input int idle_pct, input logic fixed, input answer_type fixed_answer);
      answer_type predicted;
      if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < idle_pct);
      end
      start     <= 1'b1;
      req_cmd   <= cmd;
      req_first <= first;
      req_value <= value;
      do @(posedge clock); while (busy !== 1'b0);
      predicted = compute_lookup(cmd, first, value);
      pending_answers.push_back(fixed ? fixed_answer : predicted);
      issued_total++;
   endtask

   task automatic load_sorted(input int size, input int idle_pct, input logic fine_steps);
      value_type v;
      case ($urandom_range(3))
         0: v = VMIN;
         1: v = VMAX - value_type'($urandom_range(200));
         default: v = random_value();
      endcase
      for (int i = 0; i < size; i++) begin
         issue(CMD_LOAD, i == 0, v, idle_pct, 1'b0, MISS);
         v = sat_add(v, fine_steps ? value_type'($urandom_range(5000)) : random_step());
      end
   endtask

   task automatic run_session(input int idle_pct);
      int kind;
      int size;
      kind = $urandom_range(99);
      if (kind < 75) begin
         size = ($urandom_range(7) == 0) ? $urandom_range(13, 64) : $urandom_range(1, 12);
         load_sorted(size, idle_pct, 1'b0);
         repeat ($urandom_range(1, 2 * size + 2))
            issue(CMD_QUERY, 1'($urandom_range(1)), pick_target(), idle_pct, 1'b0, MISS);
      end else if (kind < 90) begin
         size = $urandom_range(2, 12);
         for (int i = 0; i < size; i++)
            issue(CMD_LOAD, i == 0, random_value(), idle_pct, 1'b0, MISS);
         repeat ($urandom_range(1, 2 * size))
            issue(CMD_QUERY, 1'($urandom_range(1)), pick_target(), idle_pct, 1'b0, MISS);
      end else begin
         repeat ($urandom_range(1, 8))
            issue($urandom_range(1) ? CMD_QUERY : CMD_LOAD, $urandom_range(3) == 0,
                  random_value(), idle_pct, 1'b0, MISS);
      end
   endtask

   always @(posedge clock) begin : result_check
      answer_type want;
      if (!reset && rsp_valid !== 1'b0) begin
         if (pending_answers.size() == 0) begin
            report_error($sformatf("unexpected transfer: found=%b position=%0d overflow=%b",
                                   rsp_found, rsp_position, rsp_overflow));
         end else begin
            want = pending_answers.pop_front();
            if (rsp_found !== want.found)
               report_error($sformatf("found %b, want %b", rsp_found, want.found));
            if (rsp_position !== want.position)
               report_error($sformatf("position %0d, want %0d", rsp_position, want.position));
            if (rsp_overflow !== want.overflow)
               report_error($sformatf("overflow %b, want %b", rsp_overflow, want.overflow));
         end
      end
   end

   initial begin
      int phase_end;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      for (int i = 0; i < NUM_ROWS; i++)
         issue(DIRECTED_ROWS[i].cmd, DIRECTED_ROWS[i].first, DIRECTED_ROWS[i].value, 0,
               DIRECTED_ROWS[i].fixed, DIRECTED_ROWS[i].answer);
      for (int p = 0; p < 3; p++) begin
         phase_end = issued_total + PHASE_ITEMS;
         while (issued_total < phase_end)
            run_session(IDLE_PCTS[p]);
      end
      // fill the table, push past full, then restart
      load_sorted(DEPTH, 0, 1'b1);
      repeat (3)
         issue(CMD_LOAD, 1'b0, random_value(), 0, 1'b0, MISS);
      repeat (40)
         issue(CMD_QUERY, 1'($urandom_range(1)), pick_target(), 16, 1'b0, MISS);
      issue(CMD_LOAD, 1'b1, random_value(), 0, 1'b0, MISS);
      repeat (8)
         issue(CMD_QUERY, 1'($urandom_range(1)), pick_target(), 0, 1'b0, MISS);
      start <= 1'b0;
      while (pending_answers.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0)
         $display("sorted_table_predecessor_search_top regression: pass");
      else
         $display("sorted_table_predecessor_search_top regression: fail");
      $finish;
   end

   initial begin
      #5ms;
      $display("sorted_table_predecessor_search_top regression: fail");
      $finish;
   end

endmodule
